/* rtl/rls_pkg.sv */
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants of the run-length stack: commands, status
// codes, sequencer states and the word formats between controller and top.
// ----------------------------------------------------------------------------
package rls_pkg;

	localparam int VALUE_W = 32;
	localparam int SIZE_W  = 25;
	localparam int READ_W  = 7;

	localparam int DEF_ENTRY_DEPTH = 256;
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int DEF_MAX_READ    = 64;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_SAT   = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_EMIT
	} state_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [VALUE_W-1:0]  push_value;
		logic [READ_W-1:0]   read_count;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] element;
		logic               last;
		logic [SIZE_W-1:0]  virtual_size;
		logic               is_empty;
		status_t            status;
	} result_t;

endpackage

/* rtl/rls_mem.sv */
// ----------------------------------------------------------------------------
// rls_mem
// Entry store: one write port, one read port, registered read data that
// holds its value until the next read.
// ----------------------------------------------------------------------------
module rls_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/rls_ctrl.sv */
// ----------------------------------------------------------------------------
// rls_ctrl
// Sequencer of the run-length stack: reads the top entry, applies push or
// pop and writes it back, or walks down the entries for a read out.
// Holds the entry and element totals and the result register.
// ----------------------------------------------------------------------------
module rls_ctrl import rls_pkg::*; #(
	parameter int ENTRY_DEPTH = DEF_ENTRY_DEPTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int MAX_READ    = DEF_MAX_READ
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [VALUE_W-1:0]                     dflt,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  item_t                                  in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output result_t                                out_res,
	output logic                                   mem_wr_en,
	output logic [$clog2(ENTRY_DEPTH)-1:0]         mem_wr_addr,
	output logic [VALUE_W+COUNT_WIDTH-1:0]         mem_wr_data,
	output logic                                   mem_rd_en,
	output logic [$clog2(ENTRY_DEPTH)-1:0]         mem_rd_addr,
	input  logic [VALUE_W+COUNT_WIDTH-1:0]         mem_rd_data
);

	localparam int IDX_W   = $clog2(ENTRY_DEPTH);
	localparam int PTR_W   = IDX_W + 1;
	localparam int TOTAL_W = IDX_W + COUNT_WIDTH + 1;
	localparam int RW      = $clog2(MAX_READ + 1);

	state_t                  state_q, state_n;
	cmd_t                    cmd_q;
	logic [VALUE_W-1:0]      val_q;
	logic [RW-1:0]           rem_q, rem_n;
	logic [PTR_W-1:0]        ent_q, ent_n;
	logic [TOTAL_W-1:0]      tot_q, tot_n;
	logic [PTR_W-1:0]        left_q, left_n;
	logic [COUNT_WIDTH-1:0]  skip_q, skip_n;
	logic                    out_valid_q;
	result_t                 out_q;

	logic [VALUE_W-1:0]      rd_val;
	logic [COUNT_WIDTH-1:0]  rd_cnt;
	logic                    slot_free;
	logic [PTR_W-1:0]        ent_dec, left_dec, left_dec2;
	logic [READ_W-1:0]       n_clamp, n_m1;
	logic                    load_out;
	logic [VALUE_W-1:0]      res_elem;
	logic                    res_last;
	status_t                 res_status;
	logic [TOTAL_W+SIZE_W-1:0] size_ext;

	assign rd_val    = mem_rd_data[VALUE_W+COUNT_WIDTH-1:COUNT_WIDTH];
	assign rd_cnt    = mem_rd_data[COUNT_WIDTH-1:0];
	assign slot_free = !out_valid_q || out_ready;
	assign ent_dec   = ent_q - PTR_W'(1);
	assign left_dec  = left_q - PTR_W'(1);
	assign left_dec2 = left_q - PTR_W'(2);
	assign size_ext  = {{SIZE_W{1'b0}}, tot_n};
	assign n_m1      = n_clamp - READ_W'(1);

	// zero reads as one, anything above the limit as the limit
	always_comb begin
		if (in_item.read_count == '0) begin
			n_clamp = READ_W'(1);
		end else if (in_item.read_count > READ_W'(MAX_READ)) begin
			n_clamp = READ_W'(MAX_READ);
		end else begin
			n_clamp = in_item.read_count;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_n = (in_item.cmd == CMD_READ) ? S_LOAD : S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					state_n = S_IDLE;
				end
			end
			S_LOAD: begin
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					if (rem_q == '0) begin
						state_n = S_IDLE;
					end else if (left_q != '0 && skip_q == '0 && left_dec != '0) begin
						state_n = S_LOAD;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		in_ready    = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = ent_dec[IDX_W-1:0];
		mem_wr_data = mem_rd_data;
		mem_rd_en   = 1'b0;
		mem_rd_addr = ent_dec[IDX_W-1:0];
		ent_n       = ent_q;
		tot_n       = tot_q;
		left_n      = left_q;
		skip_n      = skip_q;
		rem_n       = rem_q;
		load_out    = 1'b0;
		res_elem    = '0;
		res_last    = 1'b1;
		res_status  = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// fetch the top entry; unused when the stack is empty
					mem_rd_en = 1'b1;
					left_n    = ent_q;
					rem_n     = n_m1[RW-1:0];
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					load_out = 1'b1;
					priority case (cmd_q)
						CMD_PUSH: begin
							if (val_q == dflt) begin
								// default on empty stack is dropped
								if (ent_q != '0) begin
									if (rd_cnt == '1) begin
										res_status = STAT_SAT;
									end else begin
										mem_wr_en   = 1'b1;
										mem_wr_data = {rd_val, rd_cnt + COUNT_WIDTH'(1)};
										tot_n       = tot_q + TOTAL_W'(1);
									end
								end
							end else if (ent_q == PTR_W'(ENTRY_DEPTH)) begin
								res_status = STAT_FULL;
							end else begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = ent_q[IDX_W-1:0];
								mem_wr_data = {val_q, {COUNT_WIDTH{1'b0}}};
								ent_n       = ent_q + PTR_W'(1);
								tot_n       = tot_q + TOTAL_W'(1);
							end
						end
						CMD_POP: begin
							if (ent_q == '0) begin
								res_status = STAT_EMPTY;
							end else begin
								if (rd_cnt != '0) begin
									mem_wr_en   = 1'b1;
									mem_wr_data = {rd_val, rd_cnt - COUNT_WIDTH'(1)};
								end else begin
									ent_n = ent_dec;
								end
								tot_n = tot_q - TOTAL_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LOAD: begin
				skip_n = rd_cnt;
			end
			S_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					res_last = (rem_q == '0);
					rem_n    = rem_q - RW'(1);
					if (left_q == '0) begin
						res_elem = dflt;
					end else if (skip_q != '0) begin
						res_elem = dflt;
						skip_n   = skip_q - COUNT_WIDTH'(1);
					end else begin
						res_elem = rd_val;
						left_n   = left_dec;
						// step down to the entry below
						if (left_dec != '0) begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = left_dec2[IDX_W-1:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ent_q       <= '0;
			tot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ent_q   <= ent_n;
			tot_q   <= tot_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= in_item.cmd;
			val_q <= in_item.push_value;
		end
		rem_q  <= rem_n;
		left_q <= left_n;
		skip_q <= skip_n;
		if (load_out) begin
			out_q.element      <= res_elem;
			out_q.last         <= res_last;
			out_q.virtual_size <= size_ext[SIZE_W-1:0];
			out_q.is_empty     <= (ent_n == '0);
			out_q.status       <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

/* rtl/run_length_stack_unit.sv */
// ----------------------------------------------------------------------------
// run_length_stack_unit
// Stack that keeps only non-default values, each with a count of default
// values above it; push, pop and read out of the top elements.
//
//   channel  | direction | word
//   s_axis   | in        | tuser cmd; tdata push_value, read_count
//   m_axis   | out       | tuser status; tlast last; tdata element, virtual_size,
//            |           | is_empty
//   cfg      | in        | dflt (the element kept only as a count)
//
// push, pop and no-op are accepted with the read of the top entry; the write
// back and the result follow in the exec state. a read out goes from the
// accept state to a load state and then emits its words, passing through the
// load state again each time it steps down to the next stored entry while
// words remain. reset clears the totals and the result valid; the entry memory
// is not cleared. a stalled result register holds the sequencer.
// ----------------------------------------------------------------------------
module run_length_stack_unit import rls_pkg::*; #(
	parameter int ENTRY_DEPTH = DEF_ENTRY_DEPTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int MAX_READ    = DEF_MAX_READ
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // push_value[31:0], read_count[38:32], zero
	input  logic [1:0]   s_axis_tuser,  // cmd[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // element[31:0], virtual_size[56:32],
	                                    // is_empty[57], zero
	output logic         m_axis_tlast,
	output logic [1:0]   m_axis_tuser,  // status[1:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam int IDX_W  = $clog2(ENTRY_DEPTH);
	localparam int WORD_W = VALUE_W + COUNT_WIDTH;

	logic [VALUE_W-1:0] dflt_q;
	item_t              item;
	result_t            res;
	logic               wr_en, rd_en;
	logic [IDX_W-1:0]   wr_addr, rd_addr;
	logic [WORD_W-1:0]  wr_data, rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= '0;
		end else if (cfg_valid) begin
			dflt_q <= cfg_data;
		end
	end

	assign item.cmd        = cmd_t'(s_axis_tuser);
	assign item.push_value = s_axis_tdata[31:0];
	assign item.read_count = s_axis_tdata[38:32];

	rls_ctrl #(
		.ENTRY_DEPTH (ENTRY_DEPTH),
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAX_READ    (MAX_READ)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.dflt        (dflt_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_item     (item),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (rd_en),
		.mem_rd_addr (rd_addr),
		.mem_rd_data (rd_data)
	);

	rls_mem #(
		.DEPTH (ENTRY_DEPTH),
		.WIDTH (WORD_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign m_axis_tdata = {6'b0, res.is_empty, res.virtual_size, res.element};
	assign m_axis_tlast = res.last;
	assign m_axis_tuser = res.status;

endmodule

/* bench/run_length_stack_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_stack_unit_tb
// Self-checking bench for the run-length stack. A queue of commands feeds a
// bursty stream driver; a stalling receiver takes the result words and a
// monitor checks each one against a behavioural stack kept in the bench.
// Covers the empty-stack cases, reads past the bottom and a full entry store,
// under several default values.
// ----------------------------------------------------------------------------
module run_length_stack_unit_tb;
	import rls_pkg::*;

	localparam int COUNT_MAX  = (1 << DEF_COUNT_WIDTH) - 1;
	localparam int QUIET_MAX  = 4000;
	localparam int HOLD_LEN   = 600;
	localparam int PHASE_LEN  = 12;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata = '0;  // push_value[31:0], read_count[38:32], zero
	logic [1:0]   s_axis_tuser = '0;  // cmd[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;       // element[31:0], virtual_size[56:32], is_empty[57]
	logic         m_axis_tlast;
	logic [1:0]   m_axis_tuser;       // status[1:0]
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data = '0;

	// behavioural stack
	logic [31:0]  dflt_val = '0;
	logic [31:0]  entry_val [DEF_ENTRY_DEPTH];
	int           entry_cnt [DEF_ENTRY_DEPTH];
	int           entries_held = 0;
	int           elems_held = 0;

	item_t        feed [$];
	result_t      awaited_words [$];
	int           queued_total = 0;
	int           taken_total = 0;
	int           fail_count = 0;
	int           quiet_cycles = 0;
	logic         in_took = 1'b0;
	logic         cfg_took = 1'b0;
	logic         steady_flow = 1'b0;
	logic         hold_ask = 1'b0;

	run_length_stack_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void post_word(input logic [31:0] elem, input logic fin,
	                                  input status_t st);
		result_t r;
		r.element      = elem;
		r.last         = fin;
		r.virtual_size = elems_held[SIZE_W-1:0];
		r.is_empty     = (entries_held == 0);
		r.status       = st;
		awaited_words.push_back(r);
	endfunction

	task automatic stack_step(input cmd_t op, input logic [31:0] val, input logic [6:0] rc);
		int          n;
		int          left;
		int          skip;
		int          t;
		logic [31:0] elem;
		status_t     st;
		st = STAT_OK;
		case (op)
			CMD_PUSH: begin
				if (val == dflt_val) begin
					// default on an empty stack is simply dropped
					if (entries_held > 0) begin
						t = entries_held - 1;
						if (entry_cnt[t] >= COUNT_MAX)
							st = STAT_SAT;
						else begin
							entry_cnt[t]++;
							elems_held++;
						end
					end
				end else if (entries_held >= DEF_ENTRY_DEPTH)
					st = STAT_FULL;
				else begin
					entry_val[entries_held] = val;
					entry_cnt[entries_held] = 0;
					entries_held++;
					elems_held++;
				end
				post_word('0, 1'b1, st);
			end
			CMD_POP: begin
				if (entries_held == 0)
					st = STAT_EMPTY;
				else begin
					t = entries_held - 1;
					if (entry_cnt[t] > 0)
						entry_cnt[t]--;
					else
						entries_held--;
					if (elems_held > 0)
						elems_held--;
				end
				post_word('0, 1'b1, st);
			end
			CMD_READ: begin
				n = int'(rc);
				if (n < 1)
					n = 1;
				if (n > DEF_MAX_READ)
					n = DEF_MAX_READ;
				left = entries_held;
				skip = (left > 0) ? entry_cnt[left-1] : 0;
				for (int k = 0; k < n; k++) begin
					if (left == 0)
						elem = dflt_val;
					else if (skip > 0) begin
						elem = dflt_val;
						skip--;
					end else begin
						elem = entry_val[left-1];
						left--;
						if (left > 0)
							skip = entry_cnt[left-1];
					end
					post_word(elem, k == n - 1, STAT_OK);
				end
			end
			default: post_word('0, 1'b1, STAT_OK);
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// input acceptance, result checking and config tracking
	always @(posedge clk) begin : mon_side
		result_t w;
		in_took  <= s_axis_tvalid && s_axis_tready;
		cfg_took <= cfg_valid && cfg_ready;
		if (cfg_valid && cfg_ready)
			dflt_val <= cfg_data;
		if (m_axis_tvalid && m_axis_tready) begin
			if (awaited_words.size() == 0) begin
				fail_count++;
				$error("result word with nothing expected: tdata 0x%0h", m_axis_tdata);
			end else begin
				w = awaited_words.pop_front();
				check_field("element", w.element, m_axis_tdata[31:0]);
				check_field("last", 32'(w.last), 32'(m_axis_tlast));
				check_field("virtual_size", 32'(w.virtual_size), 32'(m_axis_tdata[56:32]));
				check_field("is_empty", 32'(w.is_empty), 32'(m_axis_tdata[57]));
				check_field("status", 32'(w.status), 32'(m_axis_tuser));
			end
		end
		// results of earlier commands are checked before this one is predicted
		if (s_axis_tvalid && s_axis_tready) begin
			stack_step(cmd_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[38:32]);
			taken_total++;
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_MAX) begin
			$display("Regression FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// sender: bursts of words with random gaps in between
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin : tx_side
		item_t it;
		if (!s_axis_tvalid || in_took) begin
			if (!steady_flow && gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (feed.size() > 0) begin
				it = feed.pop_front();
				s_axis_tdata  <= {1'b0, it.read_count, it.push_value};
				s_axis_tuser  <= it.cmd;
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					                                         : $urandom_range(1, 10);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// receiver: one of four stall patterns, picked anew at random, plus one long hold
	int  pat_mode = 0;
	int  pat_left = 0;
	int  pat_phase = 0;
	int  hold_left = 0;
	bit  hold_used = 1'b0;

	always @(negedge clk) begin : rx_side
		logic rdy;
		if (hold_ask && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (pat_left == 0) begin
			pat_mode = $urandom_range(0, 3);
			pat_left = $urandom_range(20, 120);
		end
		pat_left--;
		pat_phase++;
		if (steady_flow)
			rdy = 1'b1;
		else if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			case (pat_mode)
				0:       rdy = 1'b1;
				1:       rdy = ($urandom_range(0, 9) < 6);
				2:       rdy = (pat_phase % 4 == 0);
				default: rdy = ($urandom_range(0, 15) != 0);
			endcase
		end
		m_axis_tready <= rdy;
	end

	task automatic queue_cmd(input cmd_t op, input logic [31:0] val, input logic [6:0] rc);
		item_t it;
		it.cmd        = op;
		it.push_value = val;
		it.read_count = rc;
		feed.push_back(it);
		queued_total++;
	endtask

	task automatic wait_idle;
		while (taken_total != queued_total || awaited_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_default(input logic [31:0] v);
		@(negedge clk);
		cfg_data  = v;
		cfg_valid = 1'b1;
		@(negedge clk);
		while (!cfg_took)
			@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] pick_value;
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return dflt_val;
		if (r < 5) begin
			case ($urandom_range(0, 3))
				0:       return 32'h0000_0000;
				1:       return 32'h0000_0001;
				2:       return 32'hFFFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [31:0] fresh_value;
		logic [31:0] v;
		v = $urandom();
		while (v == dflt_val)
			v = $urandom();
		return v;
	endfunction

	function automatic logic [6:0] pick_read_len;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 7'($urandom_range(1, 16));
			6, 7:             return 7'($urandom_range(17, 64));
			8:                return ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd64;
			default:          return 7'($urandom_range(65, 127));
		endcase
	endfunction

	initial begin : stimulus
		logic [31:0] phase_dflt [4];
		int          r;
		int          need;
		cmd_t        op;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-stack cases, reads past the bottom, read length limits
		write_default(32'h0000_0000);
		queue_cmd(CMD_POP, $urandom(), 7'($urandom_range(0, 127)));
		queue_cmd(CMD_PUSH, 32'h0000_0000, 7'($urandom_range(0, 127)));
		queue_cmd(CMD_READ, $urandom(), 7'd1);
		queue_cmd(CMD_READ, $urandom(), 7'd0);
		queue_cmd(CMD_NOP, 32'hFFFF_FFFF, 7'h7F);
		queue_cmd(CMD_PUSH, 32'hFFFF_FFFF, 7'h00);
		queue_cmd(CMD_PUSH, 32'h0000_0000, 7'h7F);
		queue_cmd(CMD_PUSH, 32'h0000_0000, 7'h00);
		queue_cmd(CMD_PUSH, 32'h0000_0001, 7'h55);
		queue_cmd(CMD_PUSH, 32'h0000_0000, 7'h2A);
		queue_cmd(CMD_READ, 32'h0000_0000, 7'd7);
		queue_cmd(CMD_READ, 32'hFFFF_FFFF, 7'd127);
		queue_cmd(CMD_READ, $urandom(), 7'd64);
		repeat (5)
			queue_cmd(CMD_POP, $urandom(), 7'($urandom_range(0, 127)));
		queue_cmd(CMD_PUSH, 32'h8000_0000, 7'd3);
		queue_cmd(CMD_READ, $urandom(), 7'd3);
		queue_cmd(CMD_POP, $urandom(), 7'd0);
		queue_cmd(CMD_NOP, 32'h0000_0000, 7'h00);
		wait_idle();

		phase_dflt[0] = 32'hFFFF_FFFF;
		phase_dflt[1] = $urandom();
		phase_dflt[2] = 32'h0000_0001;
		phase_dflt[3] = 32'h0000_0000;
		for (int p = 0; p < 4; p++) begin
			write_default(phase_dflt[p]);
			// long receiver hold while the sender keeps offering words
			if (p == 0)
				hold_ask = 1'b1;
			for (int i = 0; i < PHASE_LEN; i++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					op = CMD_PUSH;
				else if (r < 75)
					op = CMD_POP;
				else if (r < 95)
					op = CMD_READ;
				else
					op = CMD_NOP;
				if (op == CMD_PUSH)
					queue_cmd(op, pick_value(), 7'($urandom_range(0, 127)));
				else if (op == CMD_READ)
					queue_cmd(op, $urandom(), pick_read_len());
				else
					queue_cmd(op, $urandom(), 7'($urandom_range(0, 127)));
			end
			wait_idle();
		end

		// fill the entry store, overflow it, then work on the top count
		write_default($urandom());
		steady_flow = 1'b1;
		need = DEF_ENTRY_DEPTH - entries_held;
		for (int i = 0; i < need; i++)
			queue_cmd(CMD_PUSH, fresh_value(), 7'($urandom_range(0, 127)));
		queue_cmd(CMD_PUSH, fresh_value(), 7'd0);
		queue_cmd(CMD_READ, $urandom(), 7'd64);
		queue_cmd(CMD_PUSH, dflt_val, 7'h7F);
		queue_cmd(CMD_READ, $urandom(), 7'd0);
		queue_cmd(CMD_POP, $urandom(), 7'd0);
		queue_cmd(CMD_PUSH, dflt_val, 7'd0);
		queue_cmd(CMD_PUSH, dflt_val, 7'd0);
		queue_cmd(CMD_PUSH, fresh_value(), 7'd0);
		queue_cmd(CMD_NOP, $urandom(), 7'd0);
		queue_cmd(CMD_READ, $urandom(), 7'd127);
		wait_idle();

		repeat (40) @(posedge clk);
		if (awaited_words.size() != 0)
			$error("%0d result words never arrived", awaited_words.size());
		if (fail_count == 0 && awaited_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
